@@ hdl/ctf_pkg.sv @@
package ctf_pkg;

  localparam int DW = 34;

  localparam logic [63:0] PI_Q32      = 64'd13493037705;
  localparam logic [63:0] HALF_PI_Q32 = 64'd6746518852;
  localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;
  // ceil(2^60 / 15625), exact reciprocal for dividends up to 2^46
  localparam logic [47:0] RECIP_15625 = 48'd73786976294839;

  typedef struct packed {
    logic                 start;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
  } cordic_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [DW-1:0] angle;
    logic signed [DW-1:0] mag;
  } cordic_rsp_t;

  // Q32 angle rounded half up to the stored angle format
  function automatic logic [DW-1:0] q32_to_angle(input logic [63:0] v, input int frac);
    logic [63:0] t;
    t = (v + (64'd1 << (31 - frac))) >> (32 - frac);
    return t[DW-1:0];
  endfunction

  function automatic logic [63:0] atan_q32(input logic [4:0] i);
    logic [63:0] r;
    case (i)
      5'd0:  r = 64'd3373259426;
      5'd1:  r = 64'd1991351318;
      5'd2:  r = 64'd1052175346;
      5'd3:  r = 64'd534100635;
      5'd4:  r = 64'd268086748;
      5'd5:  r = 64'd134174063;
      5'd6:  r = 64'd67103403;
      5'd7:  r = 64'd33553749;
      5'd8:  r = 64'd16777131;
      5'd9:  r = 64'd8388597;
      5'd10: r = 64'd4194303;
      5'd11: r = 64'd2097152;
      5'd12: r = 64'd1048576;
      5'd13: r = 64'd524288;
      5'd14: r = 64'd262144;
      5'd15: r = 64'd131072;
      5'd16: r = 64'd65536;
      5'd17: r = 64'd32768;
      5'd18: r = 64'd16384;
      5'd19: r = 64'd8192;
      5'd20: r = 64'd4096;
      5'd21: r = 64'd2048;
      5'd22: r = 64'd1024;
      5'd23: r = 64'd512;
      5'd24: r = 64'd256;
      5'd25: r = 64'd128;
      5'd26: r = 64'd64;
      5'd27: r = 64'd32;
      5'd28: r = 64'd16;
      5'd29: r = 64'd8;
      5'd30: r = 64'd4;
      default: r = 64'd2;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/ctf_if.sv @@
interface ctf_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] sample_x;
  logic signed [15:0] sample_y;
  logic signed [15:0] sample_z;
  logic        [31:0] timestamp_us;

  modport source (output valid, operation, sample_x, sample_y, sample_z, timestamp_us,
                  input ready);
  modport sink (input valid, operation, sample_x, sample_y, sample_z, timestamp_us,
                output ready);
endinterface

interface ctf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle_x;
  logic signed [15:0] angle_y;
  logic signed [15:0] angle_z;

  modport source (output valid, angle_x, angle_y, angle_z, input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

@@ hdl/ctf_cordic.sv @@
module ctf_cordic #(
  parameter int STAGES = 16,
  parameter int FRAC   = 29
) (
  input  logic                clk,
  input  logic                rst,
  input  ctf_pkg::cordic_req_t req,
  output ctf_pkg::cordic_rsp_t rsp
);

  localparam int IW = $clog2(STAGES);
  localparam logic [IW-1:0] LAST = IW'(STAGES - 1);
  localparam logic signed [ctf_pkg::DW-1:0] HALF_PI =
    ctf_pkg::q32_to_angle(ctf_pkg::HALF_PI_Q32, FRAC);

  typedef enum logic {IDLE, RUN} state_t;

  state_t                          state;
  logic signed [ctf_pkg::DW-1:0]   xr, yr, zr;
  logic        [IW-1:0]            idx;
  logic                            done;
  logic signed [ctf_pkg::DW-1:0]   dx, dy, step;

  assign dx   = yr >>> idx;
  assign dy   = xr >>> idx;
  assign step = ctf_pkg::q32_to_angle(ctf_pkg::atan_q32(5'(idx)), FRAC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
      idx   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (req.start) begin
            idx <= '0;
            if (req.x == '0 && req.y == '0) begin
              xr   <= '0;
              yr   <= '0;
              zr   <= '0;
              done <= 1'b1;
            end else begin
              state <= RUN;
              // left half plane: rotate by a quarter turn first
              if (req.x < 0) begin
                if (req.y >= 0) begin
                  xr <= req.y;
                  yr <= -req.x;
                  zr <= HALF_PI;
                end else begin
                  xr <= -req.y;
                  yr <= req.x;
                  zr <= -HALF_PI;
                end
              end else begin
                xr <= req.x;
                yr <= req.y;
                zr <= '0;
              end
            end
          end
        end
        RUN: begin
          if (!yr[ctf_pkg::DW-1]) begin
            xr <= xr + dx;
            yr <= yr - dy;
            zr <= zr + step;
          end else begin
            xr <= xr - dx;
            yr <= yr + dy;
            zr <= zr - step;
          end
          idx <= idx + 1'b1;
          if (idx == LAST) begin
            state <= IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign rsp.done  = done;
  assign rsp.angle = zr;
  assign rsp.mag   = xr;

endmodule

@@ hdl/ctf_div.sv @@
module ctf_div #(
  parameter int FRAC = 29
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [35:0]     mag,
  output logic            done,
  output logic [FRAC+4:0] quot
);

  localparam int QW = FRAC + 5;
  // (mag << (FRAC - 12)) / 1e6 equals the rescaled magnitude over 15625
  localparam int SL = (FRAC >= 18) ? FRAC - 18 : 0;
  localparam int SR = (FRAC >= 18) ? 0 : 18 - FRAC;

  logic [47:0] num;
  logic [47:0] num_r;
  logic [1:0]  part;
  logic        busy;
  logic [23:0] pa;
  logic [23:0] pb;
  logic [47:0] pprod;
  logic [95:0] addend;
  logic [95:0] sum;

  assign num   = (48'(mag) << SL) >> SR;
  assign pa    = part[0] ? num_r[47:24] : num_r[23:0];
  assign pb    = part[1] ? ctf_pkg::RECIP_15625[47:24] : ctf_pkg::RECIP_15625[23:0];
  assign pprod = pa * pb;

  always_comb begin
    if (part[0] && part[1]) addend = {pprod, 48'd0};
    else if (part[0] || part[1]) addend = {24'd0, pprod, 24'd0};
    else addend = {48'd0, pprod};
  end

  // reciprocal multiplication, one 24 x 24 partial product per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      part <= '0;
      sum  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num_r <= num;
        sum   <= '0;
        part  <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        sum  <= sum + addend;
        part <= part + 1'b1;
        if (part == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = sum[60 +: QW];

endmodule

@@ hdl/imu_complementary_tilt_filter.sv @@
// Complementary tilt filter. A gyro transfer integrates its three rates over the time
// since the previous gyro transfer (angles x, y, z get -gz, -gy, +gx); an accel
// transfer computes two angles by CORDIC vectoring and blends x and z toward them with
// the gyro weight in blend_weight. One shared multiplier, one iterative CORDIC unit and
// one reciprocal-multiply divider by 1e6 do all the work under a sequencer, one item at
// a time. A gyro item takes, per axis, one multiply, one divider start and four
// partial products; a gyro item before the first accel item only records its
// timestamp and goes straight to the output. An accel item runs two CORDIC
// vectoring passes and then the blend; the first accel item skips the blend, and a
// zero vector finishes its pass without iterating.
// The next item is taken while the result waits in the output register.
module imu_complementary_tilt_filter #(
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 29
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [15:0]     cfg_data,
  ctf_in_if.sink          sample_in,
  ctf_out_if.source       angle_out
);

  localparam int F  = ANGLE_FRAC_BITS;
  localparam int QW = F + 5;
  localparam logic signed [35:0] PI_W = 36'(ctf_pkg::q32_to_angle(ctf_pkg::PI_Q32, F));
  localparam logic signed [35:0] NEG_PI_W = -PI_W;

  typedef enum logic [3:0] {
    IDLE, G_MUL, G_DIVS, G_DIVW, A_C1, A_C1W, A_GAIN, A_C2, A_C2W,
    B_X0, B_X1, B_X2, B_Z1, B_Z2, OUT
  } state_t;

  function automatic logic signed [31:0] clamp_pi(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > PI_W) r = PI_W[31:0];
    else if (v < NEG_PI_W) r = NEG_PI_W[31:0];
    else r = v[31:0];
    return r;
  endfunction

  state_t             state;
  logic signed [31:0] angle [3];
  logic               awaiting_first;
  logic [31:0]        last_gyro_time;
  logic [15:0]        blend_weight;
  logic [31:0]        dt;
  logic signed [15:0] sx, sy, sz;
  logic [1:0]         axis;
  logic signed [31:0] az, ax;
  logic signed [64:0] acc;
  logic signed [64:0] p;

  logic signed [32:0] ma;
  logic signed [31:0] mb;
  logic signed [16:0] rate;
  logic [15:0]        rate_abs;
  logic [35:0]        sat_mag;
  logic [16:0]        beta;
  logic signed [65:0] bsum;
  logic signed [35:0] gsum;
  logic signed [35:0] cur;

  ctf_pkg::cordic_req_t creq;
  ctf_pkg::cordic_rsp_t crsp;
  logic                 div_start;
  logic                 div_done;
  logic [QW-1:0]        quot;

  ctf_cordic #(.STAGES(CORDIC_STAGES), .FRAC(F)) u_cordic (
    .clk (clk), .rst (rst), .req (creq), .rsp (crsp)
  );

  ctf_div #(.FRAC(F)) u_div (
    .clk (clk), .rst (rst), .start (div_start), .mag (sat_mag),
    .done (div_done), .quot (quot)
  );

  always_comb begin
    unique case (axis)
      2'd0:    rate = -{sz[15], sz};
      2'd1:    rate = -{sy[15], sy};
      2'd2:    rate = {sx[15], sx};
      default: rate = '0;
    endcase
  end

  assign rate_abs = rate[16] ? 16'(-rate) : rate[15:0];
  assign sat_mag  = (p > 65'sh8_0000_0000) ? 36'h8_0000_0000 : p[35:0];
  assign beta     = 17'h10000 - 17'(blend_weight);
  assign bsum     = 66'(acc) + 66'(p) + 66'sd32768;
  assign cur      = 36'(angle[axis]);
  assign gsum     = rate[16] ? cur - $signed(36'(quot)) : cur + $signed(36'(quot));
  assign div_start = (state == G_DIVS);

  // shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      G_MUL: begin
        ma = {1'b0, dt};
        mb = {16'd0, rate_abs};
      end
      A_GAIN: begin
        ma = crsp.mag[32:0];
        mb = ctf_pkg::INV_GAIN_Q30;
      end
      B_X0: begin
        ma = 33'(angle[0]);
        mb = {16'd0, blend_weight};
      end
      B_X1: begin
        ma = 33'(ax);
        mb = {15'd0, beta};
      end
      B_X2: begin
        ma = 33'(angle[2]);
        mb = {16'd0, blend_weight};
      end
      B_Z1: begin
        ma = 33'(az);
        mb = {15'd0, beta};
      end
      default: ;
    endcase
  end

  always_comb begin
    creq.start = (state == A_C1) || (state == A_C2);
    if (state == A_C2) begin
      creq.x = p[63:30];
      creq.y = {{4{sx[15]}}, sx, 14'd0};
    end else begin
      creq.x = {{4{sz[15]}}, sz, 14'd0};
      creq.y = {{4{sy[15]}}, sy, 14'd0};
    end
  end

  assign sample_in.ready = (state == IDLE);

  always_ff @(posedge clk) begin
    p <= ma * mb;
    if (rst) begin
      state           <= IDLE;
      angle[0]        <= '0;
      angle[1]        <= '0;
      angle[2]        <= '0;
      awaiting_first  <= 1'b1;
      last_gyro_time  <= '0;
      blend_weight    <= 16'd64225;
      axis            <= '0;
      angle_out.valid <= 1'b0;
    end else begin
      if (cfg_write) blend_weight <= cfg_data;
      if (angle_out.valid && angle_out.ready && state != OUT) angle_out.valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (sample_in.valid) begin
            sx   <= sample_in.sample_x;
            sy   <= sample_in.sample_y;
            sz   <= sample_in.sample_z;
            axis <= '0;
            if (!sample_in.operation) begin
              dt             <= sample_in.timestamp_us - last_gyro_time;
              last_gyro_time <= sample_in.timestamp_us;
              state          <= awaiting_first ? OUT : G_MUL;
            end else begin
              state <= A_C1;
            end
          end
        end
        G_MUL:  state <= G_DIVS;
        G_DIVS: state <= G_DIVW;
        G_DIVW: begin
          if (div_done) begin
            angle[axis] <= clamp_pi(gsum);
            axis        <= axis + 1'b1;
            state       <= (axis == 2'd2) ? OUT : G_MUL;
          end
        end
        A_C1: state <= A_C1W;
        A_C1W: begin
          if (crsp.done) begin
            az    <= clamp_pi(36'(crsp.angle));
            state <= A_GAIN;
          end
        end
        A_GAIN: state <= A_C2;
        A_C2:   state <= A_C2W;
        A_C2W: begin
          if (crsp.done) begin
            if (awaiting_first) begin
              awaiting_first <= 1'b0;
              angle[0]       <= clamp_pi(36'(crsp.angle));
              angle[1]       <= '0;
              angle[2]       <= az;
              state          <= OUT;
            end else begin
              ax    <= clamp_pi(36'(crsp.angle));
              state <= B_X0;
            end
          end
        end
        B_X0: state <= B_X1;
        B_X1: begin
          acc   <= p;
          state <= B_X2;
        end
        B_X2: begin
          angle[0] <= clamp_pi(bsum[51:16]);
          state    <= B_Z1;
        end
        B_Z1: begin
          acc   <= p;
          state <= B_Z2;
        end
        B_Z2: begin
          angle[2] <= clamp_pi(bsum[51:16]);
          state    <= OUT;
        end
        OUT: begin
          if (!angle_out.valid || angle_out.ready) begin
            angle_out.valid   <= 1'b1;
            angle_out.angle_x <= 16'(angle[0] >>> (F - 13));
            angle_out.angle_y <= 16'(angle[1] >>> (F - 13));
            angle_out.angle_z <= 16'(angle[2] >>> (F - 13));
            state             <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
